// ===== rtl/scm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scm_pkg;

	localparam logic [1:0] FUNC_LOAD    = 2'd0;
	localparam logic [1:0] FUNC_NONZERO = 2'd1;
	localparam logic [1:0] FUNC_ROW_END = 2'd2;

	localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic [1:0]         func;
		logic [9:0]         index;
		logic signed [31:0] value;
	} item_t;

	typedef struct packed {
		logic [15:0]        row;
		logic signed [63:0] row_sum;
		logic               saturated;
	} result_t;

	typedef struct packed {
		logic               valid;
		logic [1:0]         func;
		logic signed [31:0] value;
		logic               in_range;
	} stage_t;

endpackage

`default_nettype wire

// ===== rtl/scm_vec_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scm_vec_mem #(
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [31:0]              wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [31:0]                   rdata_s1
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/scm_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scm_mac #(
	parameter int ROW_COUNT_WIDTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire scm_pkg::stage_t   s1,
	input  wire logic [31:0]       x_s1,
	output logic                   blocked,
	output logic                   result_valid,
	output scm_pkg::result_t       result,
	input  wire logic              result_stall
);

	logic                       valid_s2;
	logic [1:0]                 func_s2;
	logic signed [63:0]         prod_s2;
	logic signed [63:0]         acc_q;
	logic                       sat_q;
	logic [ROW_COUNT_WIDTH-1:0] row_cnt_q;
	logic                       result_valid_q;
	scm_pkg::result_t           result_q;

	logic signed [31:0] x_eff;
	logic signed [63:0] prod;
	logic signed [63:0] sum;
	logic               ovf;
	logic signed [63:0] acc_next;
	logic               retire_end;

	assign x_eff = s1.in_range ? signed'(x_s1) : 32'sd0;
	assign prod  = s1.value * x_eff;

	assign sum      = acc_q + prod_s2;
	assign ovf      = (acc_q[63] == prod_s2[63]) && (sum[63] != acc_q[63]);
	assign acc_next = ovf ? (acc_q[63] ? scm_pkg::SUM_MIN : scm_pkg::SUM_MAX) : sum;

	assign blocked    = valid_s2 && (func_s2 == scm_pkg::FUNC_ROW_END) &&
		result_valid_q && result_stall;
	assign retire_end = advance && valid_s2 && (func_s2 == scm_pkg::FUNC_ROW_END);

	always_ff @(posedge clk) begin
		if (advance) begin
			func_s2 <= s1.func;
			prod_s2 <= prod;
		end
		if (retire_end) begin
			result_q.row       <= 16'(row_cnt_q);
			result_q.row_sum   <= acc_q;
			result_q.saturated <= sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2       <= 1'b0;
			acc_q          <= '0;
			sat_q          <= 1'b0;
			row_cnt_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_s2 <= s1.valid;
				if (valid_s2) begin
					case (func_s2)
						scm_pkg::FUNC_NONZERO: begin
							acc_q <= acc_next;
							if (ovf) begin
								sat_q <= 1'b1;
							end
						end
						scm_pkg::FUNC_ROW_END: begin
							acc_q     <= '0;
							sat_q     <= 1'b0;
							row_cnt_q <= row_cnt_q + 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			if (retire_end) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ===== rtl/sparse_csr_matvec.sv =====
// A row result is registered after its end-of-row beat passes the s1 and s2 stages.
// Throughput: one item per cycle when not stalled; the vector store has one write
// and one read port; the multiply and the saturating accumulate sit in separate
// stages. Input stalls only while a finished row waits behind an unread result.
// Reset clears the row sum, the saturation flag, the row counter and the pipeline;
// the vector store is not cleared and holds nothing useful until loaded.
`timescale 1ns / 1ps
`default_nettype none

module sparse_csr_matvec #(
	parameter int VECTOR_DEPTH    = 1024,
	parameter int ROW_COUNT_WIDTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire scm_pkg::item_t    item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output scm_pkg::result_t       result
);

	localparam int AW = $clog2(VECTOR_DEPTH);

	logic            advance;
	logic            blocked;
	logic            accept;
	logic            in_range;
	logic [AW-1:0]   addr;
	logic [31:0]     x_s1;
	scm_pkg::stage_t s1;

	assign advance    = !blocked;
	assign item_stall = blocked;
	assign accept     = item_valid && advance;
	assign in_range   = 32'(item.index) < 32'(VECTOR_DEPTH);
	assign addr       = AW'(item.index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1 <= '0;
		end else if (advance) begin
			s1.valid    <= item_valid;
			s1.func     <= item.func;
			s1.value    <= item.value;
			s1.in_range <= in_range;
		end
	end

	scm_vec_mem #(
		.DEPTH(VECTOR_DEPTH)
	) u_mem (
		.clk     (clk),
		.we      (accept && (item.func == scm_pkg::FUNC_LOAD) && in_range),
		.waddr   (addr),
		.wdata   (item.value),
		.re      (advance),
		.raddr   (addr),
		.rdata_s1(x_s1)
	);

	scm_mac #(
		.ROW_COUNT_WIDTH(ROW_COUNT_WIDTH)
	) u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.s1          (s1),
		.x_s1        (x_s1),
		.blocked     (blocked),
		.result_valid(result_valid),
		.result      (result),
		.result_stall(result_stall)
	);

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled without a waiting result");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1.valid)
		else $error("accepted item missing from first stage");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s1.valid && !advance |=> s1.valid)
		else $error("first stage item lost during stall");

endmodule

`default_nettype wire

// ===== tb/tb_sparse_csr_matvec.sv =====
`timescale 1ns / 1ps

module tb_sparse_csr_matvec;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 500000;

	class row_sum_board;
		logic signed [31:0] vec_mem [1024];
		logic signed [63:0] run_sum  = '0;
		logic        [15:0] row_num  = '0;
		logic               sat_seen = 1'b0;
		scm_pkg::result_t   rows_due [$];
		int errors  = 0;
		int n_items = 0;
		int n_rows  = 0;
		int n_sat   = 0;

		function void note_item(scm_pkg::item_t it);
			logic signed [63:0] a, b, s;
			scm_pkg::result_t r;
			n_items++;
			case (it.func)
				scm_pkg::FUNC_LOAD: vec_mem[it.index] = it.value;
				scm_pkg::FUNC_NONZERO: begin
					a = {{32{it.value[31]}}, it.value};
					b = {{32{vec_mem[it.index][31]}}, vec_mem[it.index]};
					a = a * b;
					s = run_sum + a;
					if (run_sum[63] == a[63] && s[63] != run_sum[63]) begin
						sat_seen = 1'b1;
						run_sum = run_sum[63] ? scm_pkg::SUM_MIN : scm_pkg::SUM_MAX;
					end else begin
						run_sum = s;
					end
				end
				scm_pkg::FUNC_ROW_END: begin
					r.row = row_num;
					r.row_sum = run_sum;
					r.saturated = sat_seen;
					rows_due.push_back(r);
					run_sum = '0;
					sat_seen = 1'b0;
					row_num++;
				end
				default: ;
			endcase
		endfunction

		function void check_row(scm_pkg::result_t got);
			scm_pkg::result_t want;
			if (rows_due.size() == 0) begin
				$error("row result for row %0d arrived with none expected", got.row);
				errors++;
				return;
			end
			want = rows_due.pop_front();
			n_rows++;
			if (got.saturated === 1'b1)
				n_sat++;
			if (got.row !== want.row) begin
				$error("row: expected %0d, got %0d", want.row, got.row);
				errors++;
			end
			if (got.row_sum !== want.row_sum) begin
				$error("row_sum: expected %h, got %h", want.row_sum, got.row_sum);
				errors++;
			end
			if (got.saturated !== want.saturated) begin
				$error("saturated: expected %b, got %b", want.saturated, got.saturated);
				errors++;
			end
		endfunction
	endclass

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             item_valid   = 1'b0;
	logic             item_stall;
	scm_pkg::item_t   item         = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	scm_pkg::result_t result;

	row_sum_board board;
	int       tx_max   = 16;
	int       rx_max   = 16;
	bit       hold_req = 1'b0;
	int       n_sent   = 0;
	int       cycles   = 0;
	bit       loaded [1024];
	logic [9:0] loaded_idx [$];

	sparse_csr_matvec dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #5 clk = ~clk;

	initial board = new;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			board.check_row(result);
	end

	initial begin : result_side
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				gap = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				gap = $urandom_range(0, rx_max);
			end
			if (gap > 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!(result_valid && !result_stall));
		end
	end

	task automatic drive_item(input scm_pkg::item_t it);
		int gap;
		gap = $urandom_range(0, tx_max);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		board.note_item(it);
		if (it.func != FUNC_UNUSED)
			n_sent++;
	endtask

	task automatic send(input logic [1:0] f, input logic [9:0] idx, input logic [31:0] v);
		scm_pkg::item_t it;
		it.func = f;
		it.index = idx;
		it.value = v;
		if (f == scm_pkg::FUNC_LOAD && !loaded[idx]) begin
			loaded[idx] = 1'b1;
			loaded_idx.push_back(idx);
		end
		drive_item(it);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (board.rows_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 9))
			5, 6, 7: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
			8:       return 32'h7FFF_FFFF;
			9:       return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [9:0] pick_col();
		return loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
	endfunction

	task automatic run_rows(input int count);
		int stop, nnz;
		stop = n_sent + count;
		while (n_sent < stop) begin
			case ($urandom_range(0, 19))
				0, 1: send(scm_pkg::FUNC_LOAD, 10'($urandom), rand_value());
				2:    send(FUNC_UNUSED, 10'($urandom), $urandom);
				default: begin
					nnz = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 16) : $urandom_range(0, 4);
					repeat (nnz) begin
						if ($urandom_range(0, 19) == 0)
							send(scm_pkg::FUNC_LOAD, 10'($urandom), rand_value());
						send(scm_pkg::FUNC_NONZERO, pick_col(), rand_value());
					end
					send(scm_pkg::FUNC_ROW_END, 10'($urandom), $urandom);
				end
			endcase
		end
	endtask

	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(scm_pkg::FUNC_LOAD, 10'd0, 32'h7FFF_FFFF);
		send(scm_pkg::FUNC_LOAD, 10'd1023, 32'h8000_0000);
		send(scm_pkg::FUNC_LOAD, 10'd1, 32'h0001_0000);
		send(scm_pkg::FUNC_LOAD, 10'd2, 32'hFFFF_FFFF);
		send(scm_pkg::FUNC_ROW_END, 10'd0, 32'h0);
		repeat (3) send(scm_pkg::FUNC_NONZERO, 10'd0, 32'h7FFF_FFFF);
		send(scm_pkg::FUNC_ROW_END, 10'd0, 32'h0);
		repeat (3) send(scm_pkg::FUNC_NONZERO, 10'd1023, 32'h7FFF_FFFF);
		send(scm_pkg::FUNC_ROW_END, 10'h3FF, 32'hFFFF_FFFF);
		send(FUNC_UNUSED, 10'h3FF, 32'hFFFF_FFFF);
		send(scm_pkg::FUNC_NONZERO, 10'd1, 32'h8000_0000);
		send(scm_pkg::FUNC_NONZERO, 10'd2, 32'h0000_0001);
		send(scm_pkg::FUNC_NONZERO, 10'd1023, 32'h8000_0000);
		send(scm_pkg::FUNC_ROW_END, 10'd0, 32'h0);
		send(scm_pkg::FUNC_NONZERO, 10'd0, 32'h0);
		send(scm_pkg::FUNC_ROW_END, 10'd0, 32'h0);
		send(scm_pkg::FUNC_LOAD, 10'h155, 32'hAAAA_AAAA);
		send(scm_pkg::FUNC_LOAD, 10'h2AA, 32'h5555_5555);
		send(scm_pkg::FUNC_NONZERO, 10'h155, 32'h5555_5555);
		send(scm_pkg::FUNC_NONZERO, 10'h2AA, 32'hAAAA_AAAA);
		send(scm_pkg::FUNC_ROW_END, 10'd0, 32'h0);
		wait_drained();

		tx_max = 4;
		rx_max = 4;
		repeat (40) send(scm_pkg::FUNC_LOAD, 10'($urandom), rand_value());

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0:       begin tx_max = 16; rx_max = 16; end
				1, 3:    begin tx_max = 0;  rx_max = 0;  end
				2:       begin tx_max = 0;  rx_max = 16; end
				4:       begin tx_max = 16; rx_max = 0;  end
				default: begin tx_max = $urandom_range(0, 16); rx_max = $urandom_range(0, 16); end
			endcase
			// The result side stops for a long stretch while beats keep coming.
			if (ph == 3)
				hold_req = 1'b1;
			run_rows(130);
			if (ph % 2 == 1)
				wait_drained();
		end
		wait_drained();

		$display("Sent %0d beats; checked %0d row results, %0d of them saturated.",
			board.n_items, board.n_rows, board.n_sat);
		$display("Random gaps and a long result hold were mixed in; %0d vector entries were loaded.",
			loaded_idx.size());
		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
